FILE: src/rpta_pkg.sv
package rpta_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_GRAY     = 2'd0;
    localparam logic [1:0] CFG_BRIGHT   = 2'd1;
    localparam logic [1:0] CFG_CONTRAST = 2'd2;
    localparam logic [1:0] CFG_CURVE    = 2'd3;

    // Tone curve codes
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_SINE   = 2'd1;
    localparam logic [1:0] CURVE_EXP    = 2'd2;
    localparam logic [1:0] CURVE_LOG    = 2'd3;

    localparam int CFG_W = 7;

    // Integer mean of three values: (s * 683) >> 11 is exact for s <= 765
    localparam logic [9:0] MEAN_MULT  = 10'd683;
    localparam int         MEAN_SHIFT = 11;

    // Division by the contrast divisor: n * ceil(2^22 / d) >> 22
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 17;

    localparam real PI        = 3.14159265358979323846;
    localparam real LN2       = 0.69314718055994530942;
    localparam real LOG_SCALE = 255.0 / (8.0 * LN2);
    localparam real ROM_EPS   = 1.0e-9;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    typedef struct packed {
        logic                      gray;
        logic signed [7:0]         bri_off;
        logic [6:0]                con_gain;
        logic signed [15:0]        con_bias;
        logic [RECIP_W-1:0]        con_recip;
        logic [1:0]                curve_sel;
    } cfg_t;

    typedef logic [127:0][7:0]         off_tab_t;
    typedef logic [127:0][RECIP_W-1:0] recip_tab_t;
    typedef logic [255:0][7:0]         rom_t;

    // floor(128 * p / 100) for every 7-bit signed percent p
    function automatic off_tab_t build_off_tab();
        off_tab_t tab;
        int       p;
        int       n;
        int       q;
        for (int i = 0; i < 128; i++)
        begin
            p = (i >= 64) ? i - 128 : i;
            n = 128 * p;
            q = (n >= 0) ? n / 100 : -((99 - n) / 100);
            tab[i] = 8'(q);
        end
        return tab;
    endfunction

    // ceil(2^RECIP_SHIFT / d) by shift and subtract, d above one
    function automatic logic [RECIP_W-1:0] ceil_recip(input int d);
        int rem;
        int q;
        rem = 1;
        q   = 0;
        for (int b = 0; b < RECIP_SHIFT; b++)
        begin
            rem = 2 * rem;
            q   = 2 * q;
            if (rem >= d)
            begin
                rem = rem - d;
                q   = q + 1;
            end
        end
        if (rem != 0)
            q = q + 1;
        return RECIP_W'(q);
    endfunction

    // ceil(2^22 / d), d = 100 when stretching down, 100 - c otherwise
    function automatic recip_tab_t build_recip_tab();
        recip_tab_t tab;
        int         p;
        int         d;
        for (int i = 0; i < 128; i++)
        begin
            p = (i >= 64) ? i - 128 : i;
            d = (p < 0) ? 100 : 100 - p;
            tab[i] = ceil_recip(d);
        end
        return tab;
    endfunction

    // Floor of the curve value for each code, clamped to 0..255
    function automatic rom_t build_rom(input logic [1:0] sel);
        rom_t rom;
        real  x;
        real  y;
        int   k;
        for (int v = 0; v < 256; v++)
        begin
            x = real'(v);
            case (sel)
                CURVE_SINE: y = 127.5 * (1.0 - $cos(PI * x / 255.0));
                CURVE_EXP:  y = $pow(2.0, 8.0 * x / 255.0) - 1.0;
                CURVE_LOG:  y = LOG_SCALE * $ln(x + 1.0);
                default:    y = x;
            endcase
            k = int'($floor(y + ROM_EPS));
            if (k < 0)
                k = 0;
            if (k > 255)
                k = 255;
            rom[v] = 8'(k);
        end
        return rom;
    endfunction

    localparam off_tab_t   BRIGHT_OFF_TAB = build_off_tab();
    localparam recip_tab_t RECIP_TAB      = build_recip_tab();
    localparam rom_t       SINE_ROM       = build_rom(CURVE_SINE);
    localparam rom_t       EXP_ROM        = build_rom(CURVE_EXP);
    localparam rom_t       LOG_ROM        = build_rom(CURVE_LOG);

endpackage

FILE: src/rpta_cfg.sv
module rpta_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [rpta_pkg::CFG_W-1:0]     cfg_data,
    output rpta_pkg::cfg_t                 cfg
);
    import rpta_pkg::*;

    logic       gray_reg;
    logic [6:0] bri_reg;
    logic [6:0] con_reg;
    logic [1:0] curve_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg  <= 1'b0;
            bri_reg   <= '0;
            con_reg   <= '0;
            curve_reg <= CURVE_LINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAY:     gray_reg  <= cfg_data[0];
                CFG_BRIGHT:   bri_reg   <= cfg_data[6:0];
                CFG_CONTRAST: con_reg   <= cfg_data[6:0];
                CFG_CURVE:    curve_reg <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    // Derive the per-setting coefficients the datapath uses
    always_comb
    begin
        cfg.gray      = gray_reg;
        cfg.bri_off   = $signed(BRIGHT_OFF_TAB[bri_reg]);
        cfg.con_gain  = con_reg[6] ? 7'(7'd100 + con_reg) : 7'd100;
        cfg.con_bias  = -($signed({{9{con_reg[6]}}, con_reg}) <<< 7);
        cfg.con_recip = RECIP_TAB[con_reg];
        cfg.curve_sel = curve_reg;
    end

endmodule

FILE: src/rpta_pre.sv
module rpta_pre (
    input  logic            clk,
    input  logic            rst_n,
    input  rpta_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  rpta_pkg::pix_t  in_pix,
    output logic            out_valid,
    input  logic            out_ready,
    output rpta_pkg::pix_t  out_pix
);
    import rpta_pkg::*;

    logic       v1_reg;
    logic       v2_reg;
    pix_t       p1_reg;
    pix_t       p2_reg;
    logic       en1;
    logic       en2;
    logic [9:0] sum;
    logic [19:0] mean_prod;
    logic [7:0] mean;
    pix_t       p1_next;
    pix_t       p2_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Grayscale: integer mean by reciprocal multiply
    always_comb
    begin
        sum       = 10'(in_pix.red) + 10'(in_pix.green) + 10'(in_pix.blue);
        mean_prod = 20'(sum) * 20'(MEAN_MULT);
        mean      = mean_prod[MEAN_SHIFT +: 8];
        p1_next   = in_pix;
        if (cfg.gray)
        begin
            p1_next.red   = mean;
            p1_next.green = mean;
            p1_next.blue  = mean;
        end
    end

    function automatic logic [7:0] add_clamp(input logic [7:0] v,
                                             input logic signed [7:0] off);
        logic signed [9:0] s;
        s = $signed({2'b00, v}) + 10'(off);
        if (s < 0)
            return 8'd0;
        else if (s > 10'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

    // Brightness: add the offset and clamp
    always_comb
    begin
        p2_next       = p1_reg;
        p2_next.red   = add_clamp(p1_reg.red,   cfg.bri_off);
        p2_next.green = add_clamp(p1_reg.green, cfg.bri_off);
        p2_next.blue  = add_clamp(p1_reg.blue,  cfg.bri_off);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
            p1_reg <= p1_next;
        if (en2 && v1_reg)
            p2_reg <= p2_next;
    end

    assign out_valid = v2_reg;
    assign out_pix   = p2_reg;

endmodule

FILE: src/rpta_contrast.sv
module rpta_contrast (
    input  logic            clk,
    input  logic            rst_n,
    input  rpta_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  rpta_pkg::pix_t  in_pix,
    output logic            out_valid,
    input  logic            out_ready,
    output rpta_pkg::pix_t  out_pix
);
    import rpta_pkg::*;

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [2:0][15:0]  num_reg;
    logic signed [2:0][15:0]  num_next;
    logic [7:0]               alpha1_reg;
    pix_t                     p2_reg;
    pix_t                     p2_next;
    logic                     en1;
    logic                     en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    function automatic logic signed [15:0] numer(input logic [7:0] v,
                                                 input logic [6:0] gain,
                                                 input logic signed [15:0] bias);
        logic [14:0] prod;
        prod = 15'(gain) * 15'(v);
        return $signed({1'b0, prod}) + bias;
    endfunction

    function automatic logic [7:0] quot(input logic signed [15:0] n,
                                        input logic [RECIP_W-1:0] recip);
        logic [14:0] mag;
        logic [31:0] prod;
        logic [9:0]  q;
        mag  = (n < 0) ? 15'd0 : n[14:0];
        prod = 32'(mag) * 32'(recip);
        q    = prod[RECIP_SHIFT +: 10];
        return (q > 10'd255) ? 8'd255 : q[7:0];
    endfunction

    // Numerator about the midpoint
    always_comb
    begin
        num_next[0] = numer(in_pix.red,   cfg.con_gain, cfg.con_bias);
        num_next[1] = numer(in_pix.green, cfg.con_gain, cfg.con_bias);
        num_next[2] = numer(in_pix.blue,  cfg.con_gain, cfg.con_bias);
    end

    // Divide by reciprocal multiply, drop negatives and clamp
    always_comb
    begin
        p2_next.red   = quot(num_reg[0], cfg.con_recip);
        p2_next.green = quot(num_reg[1], cfg.con_recip);
        p2_next.blue  = quot(num_reg[2], cfg.con_recip);
        p2_next.alpha = alpha1_reg;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            num_reg    <= num_next;
            alpha1_reg <= in_pix.alpha;
        end
        if (en2 && v1_reg)
            p2_reg <= p2_next;
    end

    assign out_valid = v2_reg;
    assign out_pix   = p2_reg;

endmodule

FILE: src/rpta_curve.sv
module rpta_curve (
    input  logic            clk,
    input  logic            rst_n,
    input  rpta_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  rpta_pkg::pix_t  in_pix,
    output logic            out_valid,
    input  logic            out_ready,
    output rpta_pkg::pix_t  out_pix
);
    import rpta_pkg::*;

    logic v_reg;
    pix_t p_reg;
    pix_t p_next;
    logic en;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    function automatic logic [7:0] lookup(input logic [7:0] v, input logic [1:0] sel);
        case (sel)
            CURVE_SINE: return SINE_ROM[v];
            CURVE_EXP:  return EXP_ROM[v];
            CURVE_LOG:  return LOG_ROM[v];
            default:    return v;
        endcase
    endfunction

    // Map each colour through the selected curve
    always_comb
    begin
        p_next.red   = lookup(in_pix.red,   cfg.curve_sel);
        p_next.green = lookup(in_pix.green, cfg.curve_sel);
        p_next.blue  = lookup(in_pix.blue,  cfg.curve_sel);
        p_next.alpha = in_pix.alpha;
    end

    // Hold the output until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            p_reg <= p_next;
    end

    assign out_valid = v_reg;
    assign out_pix   = p_reg;

endmodule

FILE: src/rgb_pixel_tone_adjust_top.sv
// Channel   Direction  Transaction
// s_axis    in         one RGBA8 source pixel
// m_axis    out        one adjusted RGBA8 pixel
// cfg       in         register write, index 0 gray, 1 brightness,
//                      2 contrast, 3 curve select
//
// One pixel per clock sustained while m_axis_tready is high; five register
// stages (mean, brightness, contrast numerator, contrast divide, curve ROM).
// Reset clears the valid bits and the configuration registers; the curve ROMs are constants.
// A stall on m_axis holds every full stage; empty stages still take data.
module rgb_pixel_tone_adjust_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [rpta_pkg::CFG_W-1:0]  cfg_data
);
    import rpta_pkg::*;

    cfg_t cfg;
    pix_t in_pix;
    pix_t pre_pix;
    pix_t con_pix;
    pix_t out_pix;
    logic pre_valid;
    logic pre_ready;
    logic con_valid;
    logic con_ready;

    // Unpack the incoming pixel
    always_comb
    begin
        in_pix.red   = s_axis_tdata[7:0];
        in_pix.green = s_axis_tdata[15:8];
        in_pix.blue  = s_axis_tdata[23:16];
        in_pix.alpha = s_axis_tdata[31:24];
    end

    rpta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpta_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_pix   (pre_pix)
    );

    rpta_contrast u_contrast (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_pix    (pre_pix),
        .out_valid (con_valid),
        .out_ready (con_ready),
        .out_pix   (con_pix)
    );

    rpta_curve u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (con_valid),
        .in_ready  (con_ready),
        .in_pix    (con_pix),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (out_pix)
    );

    // Pack the result pixel
    assign m_axis_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};

endmodule
